FILE: hw/rtl/wmc_pkg.sv
`default_nettype none

package wmc_pkg;

  // Sub-mode counts
  localparam int GAIT_MODES_DEF = 4;
  localparam int STAB_MODES_DEF = 4;

  // Field widths
  localparam int BTN_W  = 9;
  localparam int AXIS_W = 16;
  localparam int DIST_W = 16;
  localparam int DB_W   = 15;
  localparam int IDX_W  = 4;
  localparam int SQ_W   = 31;   // square of a Q1.15 value, at most 2^30
  localparam int THR_W  = 2 * DB_W;
  localparam int CFG_W  = 16;

  // Configuration register indexes
  localparam logic CFG_DEADBAND = 1'b0;
  localparam logic CFG_DISARM   = 1'b1;

  // Button bit positions in pressed_edges (face buttons by pad side)
  localparam int BTN_R1     = 0;
  localparam int BTN_L1     = 1;
  localparam int BTN_FACE_W = 2;
  localparam int BTN_TRI    = 3;
  localparam int BTN_FACE_E = 4;
  localparam int BTN_RIGHT  = 5;
  localparam int BTN_LEFT   = 6;
  localparam int BTN_UP     = 7;
  localparam int BTN_DOWN   = 8;

  // Reset values of the configuration registers
  localparam logic [DB_W-1:0]   DEADBAND_RST = 15'd3277;
  localparam logic [DIST_W-1:0] DISARM_RST   = 16'd15;

  // Walker mode
  typedef enum logic [2:0] {
    M_UNARMED = 3'd0,
    M_STAND   = 3'd1,
    M_WALK    = 3'd2,
    M_STAND4  = 3'd3,
    M_WALK4   = 3'd4,
    M_ROTATE  = 3'd5,
    M_DANCE   = 3'd6
  } mode_t;

  // One tick after the squaring stage
  typedef struct packed {
    logic [BTN_W-1:0] btn;
    logic             l2h;
    logic             l2r;
    logic             near;
    logic [SQ_W-1:0]  xsq;
    logic [SQ_W-1:0]  ysq;
  } tick_t;

  // One-tick event flags
  typedef struct packed {
    logic arm;
    logic disarm;
    logic reset4;
  } pulse_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wmc_if.sv
`default_nettype none

// Input channel: one control tick
interface wmc_in_if;
  logic                       valid;
  logic                       ready;
  logic [wmc_pkg::BTN_W-1:0]  pressed_edges;
  logic                       l2_held;
  logic                       l2_released;
  logic signed [wmc_pkg::AXIS_W-1:0] stick_x;
  logic signed [wmc_pkg::AXIS_W-1:0] stick_y;
  logic [wmc_pkg::DIST_W-1:0] distance_mm;

  modport source (output valid, pressed_edges, l2_held, l2_released, stick_x, stick_y,
                  distance_mm, input ready);
  modport sink   (input valid, pressed_edges, l2_held, l2_released, stick_x, stick_y,
                  distance_mm, output ready);
endinterface

// Result channel: mode, counters and pulses after the tick
interface wmc_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                mode;
  logic [wmc_pkg::IDX_W-1:0] gait_index;
  logic [wmc_pkg::IDX_W-1:0] stab_index;
  logic                      arm_pulse;
  logic                      disarm_pulse;
  logic                      four_leg_reset;

  modport source (output valid, mode, gait_index, stab_index, arm_pulse, disarm_pulse,
                  four_leg_reset, input ready);
  modport sink   (input valid, mode, gait_index, stab_index, arm_pulse, disarm_pulse,
                  four_leg_reset, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wmc_cfg.sv
`default_nettype none

module wmc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [wmc_pkg::CFG_W-1:0]    cfg_data,
  output logic      [wmc_pkg::THR_W-1:0]    thr_sq,
  output logic      [wmc_pkg::DIST_W-1:0]   disarm_mm
);

  logic [wmc_pkg::DB_W-1:0]   deadband_r;
  logic [wmc_pkg::DIST_W-1:0] disarm_r;
  logic [wmc_pkg::THR_W-1:0]  thr_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= wmc_pkg::DEADBAND_RST;
      disarm_r   <= wmc_pkg::DISARM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wmc_pkg::CFG_DEADBAND: deadband_r <= cfg_data[wmc_pkg::DB_W-1:0];
        wmc_pkg::CFG_DISARM:   disarm_r   <= cfg_data[wmc_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Deadband squared once, registered; follows the register in the next cycle
  always_ff @(posedge clk) begin
    thr_r <= wmc_pkg::THR_W'(deadband_r) * wmc_pkg::THR_W'(deadband_r);
  end

  assign thr_sq    = thr_r;
  assign disarm_mm = disarm_r;

endmodule

`default_nettype wire

FILE: hw/rtl/wmc_mag.sv
`default_nettype none

module wmc_mag (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  wmc_in_if.sink                          in_ch,
  input  wire logic [wmc_pkg::DIST_W-1:0] disarm_mm,
  output wmc_pkg::tick_t                  s1_data,
  output logic                            s1_valid,
  input  wire logic                       s1_take
);

  logic                              s0_valid_r, s0_valid_nxt;
  logic                              s1_valid_r, s1_valid_nxt;
  logic [wmc_pkg::BTN_W-1:0]         btn_r;
  logic                              l2h_r;
  logic                              l2r_r;
  logic signed [wmc_pkg::AXIS_W-1:0] x_r;
  logic signed [wmc_pkg::AXIS_W-1:0] y_r;
  logic [wmc_pkg::DIST_W-1:0]        dist_r;
  wmc_pkg::tick_t                    s1_r;
  logic signed [2*wmc_pkg::AXIS_W-1:0] xsq;
  logic signed [2*wmc_pkg::AXIS_W-1:0] ysq;
  logic                              in_xfer;
  logic                              s0_move;

  // Stage handshake
  assign s0_move      = !s1_valid_r || s1_take;
  assign in_ch.ready  = !s0_valid_r || s0_move;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign s0_valid_nxt = in_xfer || (s0_valid_r && !s0_move);
  assign s1_valid_nxt = (s0_valid_r && s0_move) || (s1_valid_r && !s1_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      btn_r  <= in_ch.pressed_edges;
      l2h_r  <= in_ch.l2_held;
      l2r_r  <= in_ch.l2_released;
      x_r    <= in_ch.stick_x;
      y_r    <= in_ch.stick_y;
      dist_r <= in_ch.distance_mm;
    end
  end

  // Squares of both axes and the obstacle test
  assign xsq = x_r * x_r;
  assign ysq = y_r * y_r;

  always_ff @(posedge clk) begin
    if (s0_valid_r && s0_move) begin
      s1_r.btn  <= btn_r;
      s1_r.l2h  <= l2h_r;
      s1_r.l2r  <= l2r_r;
      s1_r.near <= dist_r <= disarm_mm;
      s1_r.xsq  <= xsq[wmc_pkg::SQ_W-1:0];
      s1_r.ysq  <= ysq[wmc_pkg::SQ_W-1:0];
    end
  end

  assign s1_data  = s1_r;
  assign s1_valid = s1_valid_r;

endmodule

`default_nettype wire

FILE: hw/rtl/wmc_ctrl.sv
`default_nettype none

module wmc_ctrl #(
  parameter int GAIT_MODES = wmc_pkg::GAIT_MODES_DEF,
  parameter int STAB_MODES = wmc_pkg::STAB_MODES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire wmc_pkg::tick_t            s1_data,
  input  wire logic                      s1_valid,
  output logic                           s1_take,
  input  wire logic [wmc_pkg::THR_W-1:0] thr_sq,
  wmc_out_if.source                      out_ch
);

  localparam logic [wmc_pkg::IDX_W-1:0] GAIT_MAX = wmc_pkg::IDX_W'(GAIT_MODES - 1);
  localparam logic [wmc_pkg::IDX_W-1:0] STAB_MAX = wmc_pkg::IDX_W'(STAB_MODES - 1);

  wmc_pkg::mode_t             mode_r, mode_nxt;
  logic [wmc_pkg::IDX_W-1:0]  gait_r, gait_nxt;
  logic [wmc_pkg::IDX_W-1:0]  stab_r, stab_nxt;
  wmc_pkg::pulse_t            pulse_nxt;
  wmc_pkg::pulse_t            pulse_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [wmc_pkg::SQ_W:0]     mag;
  logic                       moved;
  logic                       disarm;
  logic                       step;
  logic [wmc_pkg::IDX_W-1:0]  gait_up, gait_dn, stab_up, stab_dn;
  logic [wmc_pkg::BTN_W-1:0]  b;

  // Result register handshake
  assign s1_take       = !out_valid_r || out_ch.ready;
  assign step          = s1_valid && s1_take;
  assign out_valid_nxt = s1_take ? s1_valid : out_valid_r;

  // Stick test and disarm condition
  assign mag    = {1'b0, s1_data.xsq} + {1'b0, s1_data.ysq};
  assign moved  = mag > (wmc_pkg::SQ_W + 1)'(thr_sq);
  assign b      = s1_data.btn;
  assign disarm = b[wmc_pkg::BTN_R1] || s1_data.near;

  // Wrapping counter steps
  assign gait_up = (gait_r >= GAIT_MAX) ? '0 : gait_r + 1'b1;
  assign gait_dn = (gait_r == '0) ? GAIT_MAX : gait_r - 1'b1;
  assign stab_up = (stab_r >= STAB_MAX) ? '0 : stab_r + 1'b1;
  assign stab_dn = (stab_r == '0) ? STAB_MAX : stab_r - 1'b1;

  // Next mode and counters
  always_comb begin
    mode_nxt = mode_r;
    gait_nxt = gait_r;
    stab_nxt = stab_r;
    if (disarm) begin
      mode_nxt = wmc_pkg::M_UNARMED;
    end else begin
      unique case (mode_r)
        wmc_pkg::M_UNARMED: begin
          if (b[wmc_pkg::BTN_L1]) mode_nxt = wmc_pkg::M_STAND;
        end
        wmc_pkg::M_STAND, wmc_pkg::M_WALK: begin
          if (b[wmc_pkg::BTN_FACE_W])     mode_nxt = wmc_pkg::M_STAND4;
          else if (b[wmc_pkg::BTN_TRI])   mode_nxt = wmc_pkg::M_DANCE;
          else if (b[wmc_pkg::BTN_RIGHT]) gait_nxt = gait_up;
          else if (b[wmc_pkg::BTN_LEFT])  gait_nxt = gait_dn;
          else if (b[wmc_pkg::BTN_UP])    stab_nxt = stab_up;
          else if (b[wmc_pkg::BTN_DOWN])  stab_nxt = stab_dn;
          else if (s1_data.l2h)           mode_nxt = wmc_pkg::M_ROTATE;
          else if (mode_r == wmc_pkg::M_STAND) begin
            if (moved) mode_nxt = wmc_pkg::M_WALK;
          end else if (!moved) begin
            mode_nxt = wmc_pkg::M_STAND;
          end
        end
        wmc_pkg::M_WALK4: begin
          if (b[wmc_pkg::BTN_FACE_E]) mode_nxt = wmc_pkg::M_STAND;
          else if (!moved)            mode_nxt = wmc_pkg::M_STAND4;
        end
        wmc_pkg::M_STAND4: begin
          if (b[wmc_pkg::BTN_FACE_E]) mode_nxt = wmc_pkg::M_STAND;
          else if (moved)             mode_nxt = wmc_pkg::M_WALK4;
        end
        wmc_pkg::M_ROTATE: begin
          if (s1_data.l2r) mode_nxt = wmc_pkg::M_STAND;
        end
        wmc_pkg::M_DANCE: begin
          if (b[wmc_pkg::BTN_FACE_E]) mode_nxt = wmc_pkg::M_STAND;
        end
        default: ;  // unused code holds until a disarm
      endcase
    end
  end

  // One-tick pulses
  always_comb begin
    pulse_nxt.disarm = disarm;
    pulse_nxt.arm    = !disarm && (mode_r == wmc_pkg::M_UNARMED) && b[wmc_pkg::BTN_L1];
    pulse_nxt.reset4 = !disarm && ((mode_r == wmc_pkg::M_STAND) || (mode_r == wmc_pkg::M_WALK))
                       && b[wmc_pkg::BTN_FACE_W];
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= wmc_pkg::M_UNARMED;
      gait_r      <= '0;
      stab_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        mode_r <= mode_nxt;
        gait_r <= gait_nxt;
        stab_r <= stab_nxt;
      end
    end
  end

  // Pulses of the result; mode and counters come straight from the state
  always_ff @(posedge clk) begin
    if (step) pulse_r <= pulse_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.mode           = mode_r;
  assign out_ch.gait_index     = gait_r;
  assign out_ch.stab_index     = stab_r;
  assign out_ch.arm_pulse      = pulse_r.arm;
  assign out_ch.disarm_pulse   = pulse_r.disarm;
  assign out_ch.four_leg_reset = pulse_r.reset4;

endmodule

`default_nettype wire

FILE: hw/rtl/walker_mode_controller.sv
// Walking-robot mode controller.
// in_ch carries one control tick (button-press edges, L2 flags, left stick
// axes, range distance); out_ch returns one result per tick: mode, gait and
// stabilisation indexes after the update, and arm, disarm and four-leg-reset
// pulses. Both channels transfer on valid and ready high at a clock edge.
// cfg_we writes register cfg_index (0 stick deadband, 1 disarm distance)
// with cfg_data; write only while no tick is in flight.
// A tick passes the input register at its transfer, then the axis squaring
// register, then the mode update into the result register, where its result
// becomes valid.
// Throughput is one tick per cycle while out_ch.ready stays high; the mode
// state lives in the result stage so consecutive ticks chain without a gap.
// Synchronous active-low reset clears the mode to unarmed, both indexes to
// zero, the registers to deadband 3277 and distance 15, and empties the pipe.
// When out_ch.ready is low the result holds and the stages behind it fill;
// in_ch.ready drops only once all three stages hold a tick.
`default_nettype none

module walker_mode_controller #(
  parameter int GAIT_MODES = wmc_pkg::GAIT_MODES_DEF,
  parameter int STAB_MODES = wmc_pkg::STAB_MODES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  wmc_in_if.sink                         in_ch,
  wmc_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [wmc_pkg::CFG_W-1:0] cfg_data
);

  logic [wmc_pkg::THR_W-1:0]  thr_sq;
  logic [wmc_pkg::DIST_W-1:0] disarm_mm;
  wmc_pkg::tick_t             s1_data;
  logic                       s1_valid;
  logic                       s1_take;

  wmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr_sq    (thr_sq),
    .disarm_mm (disarm_mm)
  );

  wmc_mag u_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .disarm_mm (disarm_mm),
    .s1_data   (s1_data),
    .s1_valid  (s1_valid),
    .s1_take   (s1_take)
  );

  wmc_ctrl #(
    .GAIT_MODES (GAIT_MODES),
    .STAB_MODES (STAB_MODES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_data  (s1_data),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .thr_sq   (thr_sq),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

FILE: tb/sv/walker_mode_controller_tb.sv
`timescale 1ns / 1ps

module walker_mode_controller_tb;

  // One control tick as driven on the input channel
  typedef struct packed {
    logic [wmc_pkg::BTN_W-1:0]         buttons;
    logic                              l2_held;
    logic                              l2_released;
    logic signed [wmc_pkg::AXIS_W-1:0] stick_x;
    logic signed [wmc_pkg::AXIS_W-1:0] stick_y;
    logic [wmc_pkg::DIST_W-1:0]        distance;
  } stim_t;

  // Mode, counters and pulses after one tick
  typedef struct packed {
    logic [2:0]                mode;
    logic [wmc_pkg::IDX_W-1:0] gait;
    logic [wmc_pkg::IDX_W-1:0] stab;
    logic                      arm;
    logic                      disarm;
    logic                      leg_reset;
  } result_t;

  // Tracks the walker mode and holds the results still owed by the block
  class mode_scoreboard;
    wmc_pkg::mode_t             mode;
    logic [wmc_pkg::IDX_W-1:0]  gait;
    logic [wmc_pkg::IDX_W-1:0]  stab;
    logic [wmc_pkg::DB_W-1:0]   deadband;
    logic [wmc_pkg::DIST_W-1:0] disarm_mm;
    result_t                    owed_q[$];
    int                         errors;

    function new();
      mode      = wmc_pkg::M_UNARMED;
      gait      = '0;
      stab      = '0;
      deadband  = wmc_pkg::DEADBAND_RST;
      disarm_mm = wmc_pkg::DISARM_RST;
      errors    = 0;
    endfunction

    function void set_reg(logic idx, logic [wmc_pkg::CFG_W-1:0] val);
      if (idx == wmc_pkg::CFG_DEADBAND) begin
        deadband = val[wmc_pkg::DB_W-1:0];
      end else begin
        disarm_mm = val[wmc_pkg::DIST_W-1:0];
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Advance the mode for one accepted tick and queue the result it owes
    function void note_tick(stim_t t);
      longint  sx;
      longint  sy;
      longint  radius_sq;
      longint  limit_sq;
      logic    moved;
      result_t r;
      sx        = t.stick_x;
      sy        = t.stick_y;
      radius_sq = sx * sx + sy * sy;
      limit_sq  = longint'(deadband) * longint'(deadband);
      moved     = radius_sq > limit_sq;
      r         = '0;

      if (t.buttons[wmc_pkg::BTN_R1] || t.distance <= disarm_mm) begin
        // disarm wins over everything, counters untouched
        r.disarm = 1'b1;
        mode     = wmc_pkg::M_UNARMED;
      end else begin
        case (mode)
          wmc_pkg::M_UNARMED: begin
            if (t.buttons[wmc_pkg::BTN_L1]) begin
              r.arm = 1'b1;
              mode  = wmc_pkg::M_STAND;
            end
          end
          wmc_pkg::M_STAND, wmc_pkg::M_WALK: begin
            // first matching press decides
            if (t.buttons[wmc_pkg::BTN_FACE_W]) begin
              mode        = wmc_pkg::M_STAND4;
              r.leg_reset = 1'b1;
            end else if (t.buttons[wmc_pkg::BTN_TRI]) begin
              mode = wmc_pkg::M_DANCE;
            end else if (t.buttons[wmc_pkg::BTN_RIGHT]) begin
              gait = wmc_pkg::IDX_W'((int'(gait) + 1) % wmc_pkg::GAIT_MODES_DEF);
            end else if (t.buttons[wmc_pkg::BTN_LEFT]) begin
              gait = wmc_pkg::IDX_W'((int'(gait) + wmc_pkg::GAIT_MODES_DEF - 1)
                                     % wmc_pkg::GAIT_MODES_DEF);
            end else if (t.buttons[wmc_pkg::BTN_UP]) begin
              stab = wmc_pkg::IDX_W'((int'(stab) + 1) % wmc_pkg::STAB_MODES_DEF);
            end else if (t.buttons[wmc_pkg::BTN_DOWN]) begin
              stab = wmc_pkg::IDX_W'((int'(stab) + wmc_pkg::STAB_MODES_DEF - 1)
                                     % wmc_pkg::STAB_MODES_DEF);
            end else if (t.l2_held) begin
              mode = wmc_pkg::M_ROTATE;
            end else if (mode == wmc_pkg::M_STAND) begin
              if (moved) mode = wmc_pkg::M_WALK;
            end else if (!moved) begin
              mode = wmc_pkg::M_STAND;
            end
          end
          wmc_pkg::M_WALK4: begin
            if (t.buttons[wmc_pkg::BTN_FACE_E]) mode = wmc_pkg::M_STAND;
            else if (!moved) mode = wmc_pkg::M_STAND4;
          end
          wmc_pkg::M_STAND4: begin
            if (t.buttons[wmc_pkg::BTN_FACE_E]) mode = wmc_pkg::M_STAND;
            else if (moved) mode = wmc_pkg::M_WALK4;
          end
          wmc_pkg::M_ROTATE: begin
            if (t.l2_released) mode = wmc_pkg::M_STAND;
          end
          wmc_pkg::M_DANCE: begin
            if (t.buttons[wmc_pkg::BTN_FACE_E]) mode = wmc_pkg::M_STAND;
          end
          default: ;
        endcase
      end

      r.mode = mode;
      r.gait = gait;
      r.stab = stab;
      owed_q.push_back(r);
    endfunction

    function void cmp_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result with none owed, got %p", $time, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      cmp_field("mode", want.mode, got.mode);
      cmp_field("gait_index", want.gait, got.gait);
      cmp_field("stab_index", want.stab, got.stab);
      cmp_field("arm_pulse", want.arm, got.arm);
      cmp_field("disarm_pulse", want.disarm, got.disarm);
      cmp_field("four_leg_reset", want.leg_reset, got.leg_reset);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [wmc_pkg::CFG_W-1:0] cfg_data;
  int                        send_idle_pct;
  int                        stall_pct;
  mode_scoreboard            sb;

  wmc_in_if  in_if ();
  wmc_out_if out_if ();

  walker_mode_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result-side backpressure
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Transfer monitor: predict on input transfers, check output transfers
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_tick('{in_if.pressed_edges, in_if.l2_held, in_if.l2_released,
                       in_if.stick_x, in_if.stick_y, in_if.distance_mm});
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.mode, out_if.gait_index, out_if.stab_index,
                out_if.arm_pulse, out_if.disarm_pulse, out_if.four_leg_reset};
        sb.check_result(got);
      end
    end
  end

  function automatic logic [wmc_pkg::BTN_W-1:0] btn_mask(int b);
    return wmc_pkg::BTN_W'(1) << b;
  endfunction

  function automatic stim_t mk_tick(logic [wmc_pkg::BTN_W-1:0] buttons, logic l2h,
                                    logic l2r, int x, int y, int distance);
    stim_t t;
    t.buttons     = buttons;
    t.l2_held     = l2h;
    t.l2_released = l2r;
    t.stick_x     = wmc_pkg::AXIS_W'(x);
    t.stick_y     = wmc_pkg::AXIS_W'(y);
    t.distance    = wmc_pkg::DIST_W'(distance);
    return t;
  endfunction

  // Stick axis: mostly inside the deadband or anywhere, some on the edges
  function automatic logic signed [wmc_pkg::AXIS_W-1:0] pick_axis(int db);
    int r;
    int a;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      a = $urandom_range(0, db / 2);
      return wmc_pkg::AXIS_W'($urandom_range(0, 1) ? -a : a);
    end else if (r < 8) begin
      return wmc_pkg::AXIS_W'($urandom());
    end
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return wmc_pkg::AXIS_W'(db);
      3:       return wmc_pkg::AXIS_W'((db < 32767) ? db + 1 : db);
      default: return wmc_pkg::AXIS_W'(-db);
    endcase
  endfunction

  // Mostly single presses with a far obstacle; arming favored while unarmed
  function automatic stim_t gen_tick();
    stim_t t;
    int    r;
    int    dd;
    dd = sb.disarm_mm;
    r  = $urandom_range(0, 99);
    if (sb.mode == wmc_pkg::M_UNARMED && $urandom_range(0, 1)) begin
      t.buttons = btn_mask(wmc_pkg::BTN_L1);
    end else if (r < 30) begin
      t.buttons = '0;
    end else if (r < 75) begin
      t.buttons = btn_mask($urandom_range(wmc_pkg::BTN_L1, wmc_pkg::BTN_DOWN));
    end else if (r < 80) begin
      t.buttons = btn_mask(wmc_pkg::BTN_R1);
    end else begin
      t.buttons = wmc_pkg::BTN_W'($urandom());
    end
    t.l2_held     = ($urandom_range(0, 99) < 15);
    t.l2_released = ($urandom_range(0, 99) < 20);
    t.stick_x     = pick_axis(sb.deadband);
    t.stick_y     = pick_axis(sb.deadband);
    r = $urandom_range(0, 99);
    if (r < 12) t.distance = wmc_pkg::DIST_W'($urandom_range(0, dd));
    else if (r < 16) t.distance = wmc_pkg::DIST_W'((dd < 65535) ? dd + $urandom_range(0, 1) : dd);
    else t.distance = wmc_pkg::DIST_W'($urandom());
    return t;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid left high.
  task automatic send_tick(input stim_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.pressed_edges <= t.buttons;
    in_if.l2_held       <= t.l2_held;
    in_if.l2_released   <= t.l2_released;
    in_if.stick_x       <= t.stick_x;
    in_if.stick_y       <= t.stick_y;
    in_if.distance_mm   <= t.distance;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait for every owed result, then let the pipe settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic program_regs(input logic [wmc_pkg::DB_W-1:0] db,
                              input logic [wmc_pkg::DIST_W-1:0] dd);
    cfg_we    <= 1'b1;
    cfg_index <= wmc_pkg::CFG_DEADBAND;
    cfg_data  <= wmc_pkg::CFG_W'(db);
    @(negedge clk);
    cfg_index <= wmc_pkg::CFG_DISARM;
    cfg_data  <= dd;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(wmc_pkg::CFG_DEADBAND, wmc_pkg::CFG_W'(db));
    sb.set_reg(wmc_pkg::CFG_DISARM, dd);
  endtask

  // Walk every mode and counter wrap at the reset thresholds
  task automatic run_directed();
    stim_t seq[$];
    seq.push_back(mk_tick('0, 0, 0, 0, 0, 15));                          // disarm at the limit
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_L1), 0, 0, 0, 0, 16));   // arm
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_FACE_W) | btn_mask(wmc_pkg::BTN_TRI),
                          0, 0, 0, 0, 1000));
    seq.push_back(mk_tick('0, 0, 0, -32768, -32768, 1000));              // walk4
    seq.push_back(mk_tick('0, 0, 0, 0, 0, 1000));                        // back to stand4
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_FACE_E), 0, 0, 0, 0, 1000));
    seq.push_back(mk_tick('0, 0, 0, 3277, 0, 1000));                     // on the deadband
    seq.push_back(mk_tick('0, 0, 0, 0, -3278, 1000));                    // just past it
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_RIGHT), 0, 0, 0, 0, 1000));
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_LEFT), 0, 0, 0, 0, 1000));
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_LEFT), 0, 0, 0, 0, 1000));   // wraps down
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_RIGHT), 0, 0, 0, 0, 1000));  // wraps up
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_DOWN), 0, 0, 0, 0, 1000));
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_UP), 0, 0, 0, 0, 1000));
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_UP) | btn_mask(wmc_pkg::BTN_DOWN),
                          0, 0, 0, 0, 1000));
    seq.push_back(mk_tick('0, 1, 0, 20000, 0, 1000));                    // rotate
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_TRI), 0, 0, 0, 0, 1000));    // ignored in rotate
    seq.push_back(mk_tick('0, 0, 1, 0, 0, 1000));
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_TRI), 0, 0, 0, 0, 1000));    // dance
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_FACE_E) | btn_mask(wmc_pkg::BTN_RIGHT),
                          0, 0, 0, 0, 1000));
    seq.push_back(mk_tick(9'h1FF, 1, 1, 0, 0, 65535));                   // R1 beats all
    seq.push_back(mk_tick(9'h1FE, 1, 1, 32767, 32767, 65535));           // arm over the rest
    seq.push_back(mk_tick(9'h1FE, 1, 1, 32767, 32767, 65535));           // four-leg press first
    seq.push_back(mk_tick(btn_mask(wmc_pkg::BTN_L1), 0, 0, 0, 0, 65535));    // no meaning in stand4
    seq.push_back(mk_tick('0, 0, 0, 0, 0, 0));                           // nearest obstacle
    foreach (seq[i]) send_tick(seq[i]);
    in_if.valid <= 1'b0;
    drain();
  endtask

  task automatic run_phase(input logic [wmc_pkg::DB_W-1:0] db,
                           input logic [wmc_pkg::DIST_W-1:0] dd,
                           input int idle_pct, input int stall, input int n,
                           input bit hold_mid);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    program_regs(db, dd);
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) begin
        // sender holds off until the block has caught up
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(negedge clk);
      end
      send_tick(gen_tick());
    end
    in_if.valid <= 1'b0;
    drain();
  endtask

  initial begin
    sb                  = new();
    send_idle_pct       = 0;
    stall_pct           = 0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = wmc_pkg::CFG_DEADBAND;
    cfg_data            = '0;
    in_if.valid         = 1'b0;
    in_if.pressed_edges = '0;
    in_if.l2_held       = 1'b0;
    in_if.l2_released   = 1'b0;
    in_if.stick_x       = '0;
    in_if.stick_y       = '0;
    in_if.distance_mm   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    run_phase(15'd0, 16'd0, 0, 0, 70, 1'b0);
    run_phase(15'd32767, 16'd15, 45, 0, 70, 1'b1);
    run_phase(15'd3277, 16'd65535, 0, 45, 25, 1'b0);
    run_phase(wmc_pkg::DB_W'($urandom_range(0, 32767)),
              wmc_pkg::DIST_W'($urandom_range(0, 2000)), 6, 6, 70, 1'b0);
    run_phase(15'd16384, 16'd300, 0, 45, 70, 1'b0);
    run_phase(wmc_pkg::DEADBAND_RST, wmc_pkg::DISARM_RST, 0, 0, 70, 1'b1);

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("walker_mode_controller: match");
    end else begin
      $display("walker_mode_controller: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("walker_mode_controller: mismatch");
    $finish;
  end

endmodule
